### hw/rtl/de_bruijn_sequence_generator_core_assert.svh
// Assertion macros shared by the de Bruijn generator RTL.
`ifndef DE_BRUIJN_SEQUENCE_GENERATOR_CORE_ASSERT_SVH
`define DE_BRUIJN_SEQUENCE_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define DBSG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define DBSG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/dbsg_pkg.sv
// Shared types and constants of the de Bruijn sequence generator.
package dbsg_pkg;

  localparam int ORDER_W    = 5;
  localparam int ALPHA_W    = 9;
  localparam int LIMIT_W    = 48;
  localparam int SYMBOL_W   = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ENDLESS  = CFG_IDX_W'(3);

  localparam logic [ORDER_W-1:0] ORDER_RST    = ORDER_W'(2);
  localparam logic [ALPHA_W-1:0] ALPHABET_RST = ALPHA_W'(2);
  localparam logic [LIMIT_W-1:0] LIMIT_RST    = LIMIT_W'(4);

  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic [ALPHA_W-1:0] symbol_count;
    logic [LIMIT_W-1:0] length_limit;
    logic               endless;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic restart;
  } q_head_t;

endpackage

### hw/rtl/dbsg_queue.sv
// Front end: accepts tick requests, tags them as restart or continue, and queues them.
`include "de_bruijn_sequence_generator_core_assert.svh"

module dbsg_queue
  import dbsg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    in_restart,
  output q_head_t head,
  input  logic    pop
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic             ent_r [Q_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;

  assign in_ready     = (cnt_r != CNT_W'(Q_DEPTH));
  assign push         = in_valid && in_ready;
  assign head.valid   = (cnt_r != '0);
  assign head.restart = ent_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= in_restart;
    end
  end

  `DBSG_ASSERT_IMP(a_q_pop_nonempty, pop, cnt_r != '0, "queue popped while empty")
  `DBSG_ASSERT_IMP(a_q_count_bound, 1'b1, cnt_r <= CNT_W'(Q_DEPTH), "queue count overflow")
  `DBSG_ASSERT_NXT(a_q_push_shows, push, head.valid, "accepted transaction missing from queue")

endmodule

### hw/rtl/dbsg_walker.sv
// Back end: walks Lyndon words with the successor rule and emits symbols.
`include "de_bruijn_sequence_generator_core_assert.svh"

module dbsg_walker
  import dbsg_pkg::*;
#(
  parameter int MAX_ORDER    = 16,
  parameter int MAX_ALPHABET = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                walk_restart,
  input  q_head_t             head,
  output logic                pop,
  output logic                idle,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SYMBOL_W-1:0] out_symbol,
  output logic                out_last
);

  localparam int IDX_W = $clog2(MAX_ORDER + 1);
  localparam int SYM_W = $clog2(MAX_ALPHABET);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_STRIP = 2'd1;
  localparam logic [1:0] ST_EXT   = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [SYM_W-1:0]    store_r [1:MAX_ORDER];
  logic [IDX_W-1:0]    p_r, p_nxt;
  logic [IDX_W-1:0]    epos_r, epos_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    ph_r, ph_nxt;
  logic [LIMIT_W-1:0]  rem_r, rem_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SYMBOL_W-1:0] out_symbol_r, out_symbol_nxt;
  logic                out_last_r, out_last_nxt;

  logic [IDX_W-1:0]    k_eff;
  logic [SYM_W-1:0]    s_max;
  logic [IDX_W-1:0]    rd_addr;
  logic [SYM_W-1:0]    rd_data;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [SYM_W-1:0]    wr_data;
  logic                clr;
  logic                out_free;
  logic                rs;
  logic [LIMIT_W-1:0]  rem_cur;
  logic [LIMIT_W-1:0]  rem_dec;
  logic [IDX_W-1:0]    p_cur;
  logic [IDX_W-1:0]    epos_cur;
  logic [IDX_W-1:0]    ph_inc;

  // Effective order and largest symbol value, saturated to the legal range.
  always_comb begin
    if (cfg.order == '0) begin
      k_eff = IDX_W'(1);
    end else if (32'(cfg.order) > MAX_ORDER) begin
      k_eff = IDX_W'(MAX_ORDER);
    end else begin
      k_eff = IDX_W'(cfg.order);
    end
    if (cfg.symbol_count < ALPHA_W'(2)) begin
      s_max = SYM_W'(1);
    end else if (32'(cfg.symbol_count) > MAX_ALPHABET) begin
      s_max = SYM_W'(MAX_ALPHABET - 1);
    end else begin
      s_max = SYM_W'(32'(cfg.symbol_count) - 32'd1);
    end
  end

  assign rd_data  = store_r[rd_addr];
  assign out_free = !out_valid_r || out_ready;
  assign rs       = head.restart;
  assign rem_cur  = rs ? cfg.length_limit : rem_r;
  assign rem_dec  = rem_cur - LIMIT_W'(1);
  assign p_cur    = rs ? IDX_W'(1) : p_r;
  assign epos_cur = rs ? '0 : epos_r;
  assign ph_inc   = (ph_r + IDX_W'(1) == p_r) ? '0 : ph_r + IDX_W'(1);

  always_comb begin
    state_nxt      = state_r;
    p_nxt          = p_r;
    epos_nxt       = epos_r;
    idx_nxt        = idx_r;
    ph_nxt         = ph_r;
    rem_nxt        = rem_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    rd_addr        = epos_r + IDX_W'(1);
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = rd_data;
    clr            = 1'b0;
    pop            = 1'b0;

    if (walk_restart) begin
      clr       = 1'b1;
      p_nxt     = IDX_W'(1);
      epos_nxt  = '0;
      state_nxt = ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (head.valid && out_free) begin
            pop      = 1'b1;
            clr      = rs;
            p_nxt    = p_cur;
            epos_nxt = epos_cur;
            rem_nxt  = rem_cur;
            if (cfg.endless || (rem_cur != '0)) begin
              out_valid_nxt  = 1'b1;
              out_symbol_nxt = rs ? '0 : SYMBOL_W'(rd_data);
              out_last_nxt   = !cfg.endless && (rem_dec == '0);
              if (!cfg.endless) begin
                rem_nxt = rem_dec;
              end
              if (epos_cur + IDX_W'(1) == p_cur) begin
                epos_nxt  = '0;
                idx_nxt   = k_eff;
                state_nxt = ST_STRIP;
              end else begin
                epos_nxt = epos_cur + IDX_W'(1);
              end
            end
          end
        end
        ST_STRIP: begin
          rd_addr = idx_r;
          if (rd_data >= s_max) begin
            if (idx_r == IDX_W'(1)) begin
              clr       = 1'b1;
              p_nxt     = IDX_W'(1);
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r - IDX_W'(1);
            end
          end else begin
            wr_en   = 1'b1;
            wr_data = rd_data + SYM_W'(1);
            p_nxt   = idx_r;
            if (idx_r == k_eff) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt   = idx_r + IDX_W'(1);
              ph_nxt    = '0;
              state_nxt = ST_EXT;
            end
          end
        end
        ST_EXT: begin
          rd_addr = idx_r - p_r;
          wr_en   = 1'b1;
          if (idx_r == k_eff) begin
            if (ph_inc == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_STRIP;
            end
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
            ph_nxt  = ph_inc;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      p_r         <= IDX_W'(1);
      epos_r      <= '0;
      idx_r       <= '0;
      ph_r        <= '0;
      rem_r       <= LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p_r         <= p_nxt;
      epos_r      <= epos_nxt;
      idx_r       <= idx_nxt;
      ph_r        <= ph_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      for (int i = 1; i <= MAX_ORDER; i++) begin
        store_r[i] <= '0;
      end
    end else if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  assign idle       = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

  `DBSG_ASSERT_IMP(a_w_no_pop_busy, state_r != ST_IDLE, !pop, "item taken while walking")
  `DBSG_ASSERT_IMP(a_w_pos_in_word, 1'b1, (p_r != '0) && (epos_r < p_r),
                   "emit position outside current word")
  `DBSG_ASSERT_IMP(a_w_ext_range, state_r == ST_EXT, (idx_r > p_r) && (idx_r <= k_eff),
                   "extension index out of range")
  `DBSG_ASSERT_NXT(a_w_pop_loads, pop && (cfg.endless || (rem_cur != '0)), out_valid,
                   "emitting item left no result")

endmodule

### hw/rtl/de_bruijn_sequence_generator_core.sv
// Top level of the de Bruijn sequence generator: configuration registers and wiring.
// A tick transaction accepted while the walker is parked passes through a queue entry and
// then the output register before the sink can take its result; a pending word step delays it.
// Throughput: one symbol per cycle inside a Lyndon word while ticks are queued and the sink
// keeps up; at each word end the walker runs a successor step (strip plus periodic extension),
// repeated for each skipped word whose length does not divide the order.
// Reset: synchronous, active low; restores order 2, alphabet 2, limit 4, not endless,
// the word "0" and a counter of 4, with no clearing pass.
module de_bruijn_sequence_generator_core
  import dbsg_pkg::*;
#(
  parameter int MAX_ORDER    = 16,
  parameter int MAX_ALPHABET = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_restart,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SYMBOL_W-1:0]   out_symbol,
  output logic                  out_last
);

  logic [ORDER_W-1:0] order_r;
  logic [ALPHA_W-1:0] alphabet_r;
  logic [LIMIT_W-1:0] limit_r;
  logic               endless_r;
  logic               cfg_fire;
  logic               walk_restart;
  cfg_t               cfg;
  q_head_t            head;
  logic               pop;
  logic               walker_idle;

  // A configuration transaction is only taken while nothing is queued and the walker
  // is parked, so a write never lands in the middle of a successor step.
  assign cfg_ready = walker_idle && !head.valid;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Changing the order or the alphabet sends the walk back to the word "0";
  // the remaining-length counter is left alone.
  assign walk_restart = cfg_fire &&
                        ((cfg_index == REG_ORDER) || (cfg_index == REG_ALPHABET));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r    <= ORDER_RST;
      alphabet_r <= ALPHABET_RST;
      limit_r    <= LIMIT_RST;
      endless_r  <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_ORDER:    order_r    <= cfg_data[ORDER_W-1:0];
        REG_ALPHABET: alphabet_r <= cfg_data[ALPHA_W-1:0];
        REG_LIMIT:    limit_r    <= cfg_data[LIMIT_W-1:0];
        REG_ENDLESS:  endless_r  <= cfg_data[0];
        default: begin
          // Writes to unknown indexes are dropped.
        end
      endcase
    end
  end

  assign cfg.order         = order_r;
  assign cfg.symbol_count  = alphabet_r;
  assign cfg.length_limit  = limit_r;
  assign cfg.endless       = endless_r;

  // The front end takes tick transactions as long as its small queue has room,
  // so the source is not held up while the walker advances to the next word.
  dbsg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .head       (head),
    .pop        (pop)
  );

  // The walker owns the word store and the counter and drives the output register,
  // which keeps a finished symbol while the sink stalls.
  dbsg_walker #(
    .MAX_ORDER    (MAX_ORDER),
    .MAX_ALPHABET (MAX_ALPHABET)
  ) u_walker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .walk_restart (walk_restart),
    .head         (head),
    .pop          (pop),
    .idle         (walker_idle),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_symbol   (out_symbol),
    .out_last     (out_last)
  );

endmodule
